[rtl/stks_pkg.sv]
// ----------------------------------------------------------------------------
// stks_pkg
// shared constants, types and helpers of the streaming top-k selector
// ----------------------------------------------------------------------------
package stks_pkg;

    localparam int MAX_KEEP      = 16;
    localparam int TOKEN_BITS    = 20;

    localparam int SCORE_W       = 16;
    localparam int TOKEN_FIELD_W = 20;
    // stored token bits: never more than the field carries
    localparam int TOKEN_W       = (TOKEN_BITS < TOKEN_FIELD_W) ? TOKEN_BITS : TOKEN_FIELD_W;
    localparam int CNT_W         = $clog2(MAX_KEEP + 1);
    localparam int KEEP_W        = 5;

    localparam int ADDR_W        = 3;
    localparam int PDATA_W       = 32;

    // register index, taken from paddr[ADDR_W-1]
    localparam logic REG_KEEP_COUNT = 1'b0;

    localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

    typedef logic [SCORE_W-1:0]       score_t;
    typedef logic [TOKEN_W-1:0]       token_t;
    typedef logic [TOKEN_FIELD_W-1:0] token_field_t;
    typedef logic [CNT_W-1:0]         count_t;
    typedef logic [KEEP_W-1:0]        keep_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
    } dp_status_t;

    function automatic token_field_t widen_token(token_t t);
        token_field_t r;
        r = '0;
        r[TOKEN_W-1:0] = t;
        return r;
    endfunction

endpackage

[rtl/stks_stream_if.sv]
// ----------------------------------------------------------------------------
// stks stream interfaces
// valid/ready channels for scored items and ranked results
// ----------------------------------------------------------------------------
interface stks_item_if;
    logic                           valid;
    logic                           ready;
    logic [stks_pkg::SCORE_W-1:0]       score;
    logic [stks_pkg::TOKEN_FIELD_W-1:0] token_index;
    logic                           end_of_set;

    modport source (output valid, output score, output token_index, output end_of_set,
                    input ready);
    modport sink   (input valid, input score, input token_index, input end_of_set,
                    output ready);
endinterface

interface stks_rank_if;
    logic                           valid;
    logic                           ready;
    logic [stks_pkg::TOKEN_FIELD_W-1:0] ranked_token;
    logic [stks_pkg::SCORE_W-1:0]       ranked_score;
    logic                           last_ranked;

    modport source (output valid, output ranked_token, output ranked_score,
                    output last_ranked, input ready);
    modport sink   (input valid, input ranked_token, input ranked_score,
                    input last_ranked, output ready);
endinterface

[rtl/stks_datapath.sv]
// ----------------------------------------------------------------------------
// stks_datapath
// sorted entry store: parallel compare and shift insert, shift-out on pop
// ----------------------------------------------------------------------------
module stks_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  stks_pkg::dp_cmd_t              cmd,
    output stks_pkg::dp_status_t           status,
    input  logic [stks_pkg::KEEP_W-1:0]    keep_count,
    input  logic [stks_pkg::SCORE_W-1:0]   in_score,
    input  logic [stks_pkg::TOKEN_W-1:0]   in_token,
    output logic [stks_pkg::SCORE_W-1:0]   top_score,
    output logic [stks_pkg::TOKEN_W-1:0]   top_token
);
    import stks_pkg::*;

    score_t score_reg [MAX_KEEP];
    token_t token_reg [MAX_KEEP];
    score_t score_next [MAX_KEEP];
    token_t token_next [MAX_KEEP];
    count_t count_reg;
    count_t count_next;

    count_t              eff_keep;
    logic [MAX_KEEP-1:0] held;
    logic [MAX_KEEP-1:0] ge;
    logic [MAX_KEEP-1:0] above_ge;
    logic                room;
    logic                beaten;
    logic                take;

    always_comb
    begin
        if (keep_count == '0)
        begin
            eff_keep = count_t'(1);
        end
        else if (int'(keep_count) > MAX_KEEP)
        begin
            eff_keep = count_t'(MAX_KEEP);
        end
        else
        begin
            eff_keep = count_t'(keep_count);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            held[i] = int'(count_reg) > i;
            ge[i]   = held[i] && (score_reg[i] >= in_score);
        end
        above_ge[0] = 1'b1;
        for (int i = 1; i < MAX_KEEP; i++)
        begin
            above_ge[i] = ge[i-1];
        end
        // new score beats at least one held entry; with no room the lowest one is evicted
        beaten = |(held & ~ge);
        room   = (count_reg < eff_keep) && (int'(count_reg) < MAX_KEEP);
        take   = cmd.insert && (room || beaten);
    end

    always_comb
    begin
        count_next = count_reg;
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            score_next[i] = score_reg[i];
            token_next[i] = token_reg[i];
        end
        if (take)
        begin
            if (room)
            begin
                count_next = count_reg + count_t'(1);
            end
            for (int i = 0; i < MAX_KEEP; i++)
            begin
                if (!ge[i] && above_ge[i])
                begin
                    score_next[i] = in_score;
                    token_next[i] = in_token;
                end
            end
            for (int i = 1; i < MAX_KEEP; i++)
            begin
                if (!ge[i] && !above_ge[i])
                begin
                    score_next[i] = score_reg[i-1];
                    token_next[i] = token_reg[i-1];
                end
            end
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - count_t'(1);
            for (int i = 0; i < MAX_KEEP - 1; i++)
            begin
                score_next[i] = score_reg[i+1];
                token_next[i] = token_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            score_reg[i] <= score_next[i];
            token_reg[i] <= token_next[i];
        end
    end

    assign top_score   = score_reg[0];
    assign top_token   = token_reg[0];
    assign status.last = (count_reg == count_t'(1));

endmodule

[rtl/stks_ctrl.sv]
// ----------------------------------------------------------------------------
// stks_ctrl
// collect / emit sequencer of the top-k selector
// ----------------------------------------------------------------------------
module stks_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_eos,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output stks_pkg::dp_cmd_t    cmd,
    input  stks_pkg::dp_status_t status
);
    import stks_pkg::*;

    localparam logic S_COLLECT = 1'b0;
    localparam logic S_EMIT    = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_COLLECT:
            begin
                in_ready   = 1'b1;
                cmd.insert = in_valid;
                if (in_valid && in_eos)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                out_valid = 1'b1;
                cmd.pop   = out_ready;
                if (out_ready && status.last)
                begin
                    state_next = S_COLLECT;
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/streaming_top_k_selector.sv]
// ----------------------------------------------------------------------------
// streaming_top_k_selector
// keeps the highest-scoring items of a set and emits them ranked on end of set
// ----------------------------------------------------------------------------
// channel   dir   handshake      payload
// items     in    valid/ready    score, token_index, end_of_set
// ranking   out   valid/ready    ranked_token, ranked_score, last_ranked
// apb       in    psel/penable   keep_count at byte address 0
//
// items without end_of_set are accepted back to back
// after an end_of_set item the n entries held (n >= 1) leave in rank order,
// one per ranking transaction; items are held off until the last one leaves
// the results come from the shift-out of the sorted entry registers
// reset empties the store and sets keep_count to 16
// ----------------------------------------------------------------------------
module streaming_top_k_selector
(
    input  logic                          clk,
    input  logic                          rst_n,
    stks_item_if.sink                     items,
    stks_rank_if.source                   ranking,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stks_pkg::ADDR_W-1:0]   paddr,
    input  logic [stks_pkg::PDATA_W-1:0]  pwdata,
    output logic [stks_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import stks_pkg::*;

    keep_t      keep_count_reg;
    dp_cmd_t    cmd;
    dp_status_t status;
    score_t     top_score;
    token_t     top_token;
    logic       keep_hit;

    assign keep_hit = (paddr[ADDR_W-1] == REG_KEEP_COUNT);
    assign pready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= KEEP_RESET;
        end
        else if (psel && penable && pwrite && keep_hit)
        begin
            keep_count_reg <= pwdata[KEEP_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (keep_hit)
        begin
            prdata[KEEP_W-1:0] = keep_count_reg;
        end
    end

    stks_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_eos    (items.end_of_set),
        .in_ready  (items.ready),
        .out_valid (ranking.valid),
        .out_ready (ranking.ready),
        .cmd       (cmd),
        .status    (status)
    );

    stks_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .keep_count (keep_count_reg),
        .in_score   (items.score),
        .in_token   (items.token_index[TOKEN_W-1:0]),
        .top_score  (top_score),
        .top_token  (top_token)
    );

    assign ranking.ranked_score = top_score;
    assign ranking.ranked_token = widen_token(top_token);
    assign ranking.last_ranked  = status.last;

endmodule

[test/streaming_top_k_selector_tb.sv]
// ----------------------------------------------------------------------------
// streaming_top_k_selector_tb
// checks the ranked output of the top-k selector against a behavioral model.
// a directed table covers field extremes, keep_count limits, tie handling,
// eviction and keep_count lowered mid-set; random sets follow under several
// keep_count values with random gaps on both channels and one long stall of
// the ranking side
// ----------------------------------------------------------------------------
module streaming_top_k_selector_tb;

    import stks_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int LONG_STALL   = 150;
    localparam int SETTLE_WAIT  = 8;
    localparam int DRAIN_WAIT   = 16;
    localparam int PHASE_ITEMS  = 13;
    localparam int NUM_PHASES   = 7;
    localparam int NUM_ROWS     = 29;
    localparam logic [ADDR_W-1:0] KEEP_ADDR = '0;

    typedef struct packed {
        token_field_t tok;
        score_t       sc;
        logic         last;
    } ranked_t;

    // one row of the directed table: a keep_count write or an item
    typedef struct packed {
        bit           cfg;
        keep_t        keep;
        score_t       score;
        token_field_t token;
        logic         eos;
        bit           typed;
        token_field_t want_tok;
        score_t       want_sc;
    } step_row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    stks_item_if item_bus ();
    stks_rank_if rank_bus ();

    streaming_top_k_selector uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_bus),
        .ranking (rank_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // model of the sorted store
    score_t       kept_score [MAX_KEEP];
    token_field_t kept_token [MAX_KEEP];
    int unsigned  kept_n;
    keep_t        keep_reg;

    ranked_t ranked_q [$];
    int      error_count;
    int      idle_cycles;
    bit      calm_phase;
    bit      long_stall_arm;

    step_row_t dir_tab [NUM_ROWS] = '{
        // after reset: a lone end-of-set item comes straight back
        '{1'b0, 5'd0,  16'h0000, 20'h00000, 1'b1, 1'b1, 20'h00000, 16'h0000},
        '{1'b0, 5'd0,  16'hFFFF, 20'hFFFFF, 1'b1, 1'b1, 20'hFFFFF, 16'hFFFF},
        // keep one: equal score does not replace, a greater one does
        '{1'b1, 5'd1,  16'h0000, 20'h00000, 1'b0, 1'b0, 20'h00000, 16'h0000},
        '{1'b0, 5'd0,  16'h1234, 20'h00001, 1'b0, 1'b0, 20'h00000, 16'h0000},
        '{1'b0, 5'd0,  16'h1234, 20'h00002, 1'b0, 1'b0, 20'h00000, 16'h0000},
        '{1'b0, 5'd0,  16'h1235, 20'h00003, 1'b1, 1'b1, 20'h00003, 16'h1235},
        // zero acts as one
        '{1'b1, 5'd0,  16'h0000, 20'h00000, 1'b0, 1'b0, 20'h00000, 16'h0000},
        '{1'b0, 5'd0,  16'h8000, 20'hAAAAA, 1'b0, 1'b0, 20'h00000, 16'h0000},
        '{1'b0, 5'd0,  16'h7FFF, 20'h55555, 1'b1, 1'b1, 20'hAAAAA, 16'h8000},
        // above the maximum acts as the maximum; fill with ties
        '{1'b1, 5'd31, 16'h0000, 20'h00000, 1'b0, 1'b0, 20'h00000, 16'h0000},
        '{1'b0, 5'd0,  16'h0100, 20'h00010, 1'b0, 1'b0, 20'h00000, 16'h0000},
        '{1'b0, 5'd0,  16'h0100, 20'h00011, 1'b0, 1'b0, 20'h00000, 16'h0000},
        '{1'b0, 5'd0,  16'h0300, 20'h00012, 1'b0, 1'b0, 20'h00000, 16'h0000},
        '{1'b0, 5'd0,  16'h0200, 20'h00013, 1'b0, 1'b0, 20'h00000, 16'h0000},
        '{1'b0, 5'd0,  16'h0100, 20'h80014, 1'b0, 1'b0, 20'h00000, 16'h0000},
        '{1'b0, 5'd0,  16'hFFFF, 20'h40015, 1'b0, 1'b0, 20'h00000, 16'h0000},
        '{1'b0, 5'd0,  16'h0000, 20'h20016, 1'b0, 1'b0, 20'h00000, 16'h0000},
        '{1'b0, 5'd0,  16'h0300, 20'h10017, 1'b0, 1'b0, 20'h00000, 16'h0000},
        '{1'b0, 5'd0,  16'h8000, 20'h08018, 1'b0, 1'b0, 20'h00000, 16'h0000},
        '{1'b0, 5'd0,  16'h0000, 20'h04019, 1'b0, 1'b0, 20'h00000, 16'h0000},
        '{1'b0, 5'd0,  16'h7FFF, 20'h0201A, 1'b0, 1'b0, 20'h00000, 16'h0000},
        '{1'b0, 5'd0,  16'h0001, 20'h0101B, 1'b0, 1'b0, 20'h00000, 16'h0000},
        '{1'b0, 5'd0,  16'h0200, 20'h0081C, 1'b0, 1'b0, 20'h00000, 16'h0000},
        '{1'b0, 5'd0,  16'hC000, 20'h0041D, 1'b0, 1'b0, 20'h00000, 16'h0000},
        '{1'b0, 5'd0,  16'h0000, 20'h0021E, 1'b0, 1'b0, 20'h00000, 16'h0000},
        '{1'b0, 5'd0,  16'h4000, 20'h0011F, 1'b0, 1'b0, 20'h00000, 16'h0000},
        // lowered mid-set: tie with the lowest is dropped, a greater one evicts
        '{1'b1, 5'd2,  16'h0000, 20'h00000, 1'b0, 1'b0, 20'h00000, 16'h0000},
        '{1'b0, 5'd0,  16'h0000, 20'h0F0F0, 1'b0, 1'b0, 20'h00000, 16'h0000},
        '{1'b0, 5'd0,  16'h0001, 20'hF0F0F, 1'b1, 1'b0, 20'h00000, 16'h0000}
    };

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h, want %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic int unsigned eff_keep();
        int unsigned k;
        k = keep_reg;
        if (k < 1)
            k = 1;
        if (k > MAX_KEEP)
            k = MAX_KEEP;
        return k;
    endfunction

    // insert after every entry whose score is greater or equal
    function automatic void place_entry(score_t s, token_field_t t);
        int unsigned pos;
        pos = 0;
        while (pos < kept_n && kept_score[pos] >= s)
            pos++;
        for (int unsigned i = kept_n; i > pos; i--)
        begin
            kept_score[i] = kept_score[i-1];
            kept_token[i] = kept_token[i-1];
        end
        kept_score[pos] = s;
        kept_token[pos] = t;
        kept_n++;
    endfunction

    function automatic void predict_ranking(score_t s, token_field_t t, logic e);
        token_field_t tk;
        ranked_t r;
        tk = '0;
        tk[TOKEN_W-1:0] = t[TOKEN_W-1:0];
        if (kept_n < eff_keep() && kept_n < MAX_KEEP)
            place_entry(s, tk);
        else if (kept_n > 0 && s > kept_score[kept_n-1])
        begin
            kept_n--;
            place_entry(s, tk);
        end
        if (e)
        begin
            for (int unsigned i = 0; i < kept_n; i++)
            begin
                r.tok  = kept_token[i];
                r.sc   = kept_score[i];
                r.last = (i + 1 == kept_n);
                ranked_q = {ranked_q, r};
            end
            kept_n = 0;
        end
    endfunction

    // entered just after a rising edge; returns at the edge of the transaction
    task automatic send_item(input score_t s, input token_field_t t, input logic e);
        int unsigned gap;
        gap = calm_phase ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid       <= 1'b1;
        item_bus.score       <= s;
        item_bus.token_index <= t;
        item_bus.end_of_set  <= e;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        predict_ranking(s, t, e);
    endtask

    // wait for the block to go idle, then write keep_count and read it back
    task automatic write_keep(input keep_t v);
        logic [PDATA_W-1:0] rd;
        item_bus.valid <= 1'b0;
        while (ranked_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= KEEP_ADDR;
        pwdata  <= {$urandom} & 32'hFFFF_FFE0 | PDATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        keep_reg = v;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[KEEP_W-1:0] !== v)
            report_mismatch("keep_count readback", 32'(rd[KEEP_W-1:0]), 32'(v));
    endtask

    // ranking side: random hold-off after each transaction outside calm phases, one long stall
    initial
    begin : rank_sink
        int unsigned hold;
        bit          stalled;
        stalled = 1'b0;
        rank_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        rank_bus.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (rank_bus.valid && rank_bus.ready)
            begin
                hold = calm_phase ? 0 : $urandom_range(0, 3);
                if (long_stall_arm && !stalled)
                begin
                    hold    = LONG_STALL;
                    stalled = 1'b1;
                end
                if (hold != 0)
                begin
                    rank_bus.ready <= 1'b0;
                    repeat (hold) @(posedge clk);
                    rank_bus.ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin : rank_check
        ranked_t want;
        if (rst_n && rank_bus.valid && rank_bus.ready)
        begin
            if (ranked_q.size() == 0)
                report_mismatch("unexpected ranking transaction",
                                32'(rank_bus.ranked_token), 32'hFFFF_FFFF);
            else
            begin
                want = ranked_q.pop_front();
                if (rank_bus.ranked_token !== want.tok)
                    report_mismatch("ranked_token", 32'(rank_bus.ranked_token),
                                    32'(want.tok));
                if (rank_bus.ranked_score !== want.sc)
                    report_mismatch("ranked_score", 32'(rank_bus.ranked_score),
                                    32'(want.sc));
                if (rank_bus.last_ranked !== want.last)
                    report_mismatch("last_ranked", 32'(rank_bus.last_ranked),
                                    32'(want.last));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((item_bus.valid && item_bus.ready) || (rank_bus.valid && rank_bus.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        keep_t        phase_keep [NUM_PHASES];
        int unsigned  sent;
        int unsigned  set_len;
        bit           narrow;
        bit           last_phase;
        logic         eos;
        score_t       s;
        ranked_t      typed_r;

        error_count    = 0;
        idle_cycles    = 0;
        calm_phase     = 1'b0;
        long_stall_arm = 1'b0;
        kept_n         = 0;
        keep_reg       = KEEP_RESET;

        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        item_bus.valid       <= 1'b0;
        item_bus.score       <= '0;
        item_bus.token_index <= '0;
        item_bus.end_of_set  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].cfg)
                write_keep(dir_tab[i].keep);
            else
            begin
                send_item(dir_tab[i].score, dir_tab[i].token, dir_tab[i].eos);
                // typed rows end sets that hold a single entry, so one result replaces the model's
                if (dir_tab[i].typed)
                begin
                    void'(ranked_q.pop_back());
                    typed_r.tok  = dir_tab[i].want_tok;
                    typed_r.sc   = dir_tab[i].want_sc;
                    typed_r.last = 1'b1;
                    ranked_q = {ranked_q, typed_r};
                end
            end
        end

        phase_keep[0] = 5'd1;
        phase_keep[1] = 5'd16;
        phase_keep[2] = 5'd0;
        phase_keep[3] = 5'd31;
        phase_keep[4] = keep_t'($urandom_range(2, 8));
        phase_keep[5] = keep_t'($urandom_range(0, 31));
        phase_keep[6] = keep_t'($urandom_range(2, 6));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_keep(phase_keep[p]);
            calm_phase = (p % 3 == 2);
            if (p == 1)
                long_stall_arm = 1'b1;
            last_phase = (p == NUM_PHASES - 1);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                set_len = $urandom_range(1, 2 * eff_keep() + 2);
                narrow  = ($urandom_range(0, 2) == 0);
                for (int unsigned j = 0; j < set_len; j++)
                begin
                    // a set cut off at a phase boundary spans a keep_count change
                    if (sent >= PHASE_ITEMS && !last_phase)
                        break;
                    eos = (j + 1 == set_len);
                    if (narrow)
                        s = score_t'($urandom_range(0, 3) << 14);
                    else
                        s = score_t'($urandom);
                    send_item(s, token_field_t'($urandom), eos);
                    sent++;
                end
            end
        end

        item_bus.valid <= 1'b0;
        while (ranked_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
rtl/stks_pkg.sv
rtl/stks_stream_if.sv
rtl/stks_datapath.sv
rtl/stks_ctrl.sv
rtl/streaming_top_k_selector.sv
test/streaming_top_k_selector_tb.sv
